// ----- hw/rtl/double_ended_queue_macros.svh -----
// Assertion macros for the double-ended queue RTL.
// Included by the modules that carry assertions; depends on a clock named clk and reset rst_n.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define DEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_ended_queue: assertion failed");
// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_ended_queue: assertion failed");
`else
`define DEQ_ASSERT_IMP(label, ante, cons)
`define DEQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/deq_pkg.sv -----
// Shared types, constants and ring helpers for the double-ended queue.
// No dependencies; used by deq_ctrl, deq_datapath and double_ended_queue.
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 64;
  localparam int OP_W    = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int SUM_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_W    = OP_W + DATA_W + POS_W;
  localparam int OUT_W   = DATA_W + STAT_W + CNT_W;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_PEEK_FRONT = 3'd5,
    OP_READ_INDEX = 3'd6,
    OP_CLEAR      = 3'd7
  } deq_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // request accepted: latch it and read memory
    logic commit;   // update state and load the result register
  } deq_cmd_t;

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // p + n modulo DEPTH, valid while p < DEPTH and n <= DEPTH
  function automatic logic [PTR_W-1:0] ring_add(logic [SUM_W-1:0] p, logic [SUM_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = p + n;
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/deq_ctrl.sv -----
// Controller for the double-ended queue: request sequencing and result valid.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output deq_pkg::deq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture   = (state_r == S_IDLE) && in_tvalid;
    // commit only when the result register is free or being emptied
    cmd.commit    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `DEQ_ASSERT_NXT(a_commit_gives_result, cmd.commit, out_valid_r)
  `DEQ_ASSERT_NXT(a_capture_then_exec, cmd.capture, state_r == S_EXEC && !in_tready)
  `DEQ_ASSERT_IMP(a_no_overwrite, cmd.commit && out_valid_r, out_tready)

endmodule

// ----- hw/rtl/deq_datapath.sv -----
// Datapath for the double-ended queue: request latch, word store, pointers, result register.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  deq_pkg::deq_cmd_t           cmd,
  input  logic [deq_pkg::OP_W-1:0]    in_operation,
  input  logic [deq_pkg::DATA_W-1:0]  in_value,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  output logic [deq_pkg::DATA_W-1:0]  out_data,
  output logic [deq_pkg::STAT_W-1:0]  out_status,
  output logic [deq_pkg::CNT_W-1:0]   out_occupancy
);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];

  deq_pkg::deq_op_t            op_r;
  logic [deq_pkg::DATA_W-1:0]  value_r;
  logic [deq_pkg::POS_W-1:0]   pos_r;
  logic [deq_pkg::DATA_W-1:0]  rd_data_r;

  logic [deq_pkg::PTR_W-1:0]   front_r, front_nxt;
  logic [deq_pkg::PTR_W-1:0]   back_r, back_nxt;
  logic [deq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [deq_pkg::DATA_W-1:0]  data_r, data_nxt;
  deq_pkg::deq_status_t        status_r, status_nxt;
  logic [deq_pkg::CNT_W-1:0]   occ_r;

  logic [deq_pkg::PTR_W-1:0]   rd_addr;
  logic [deq_pkg::PTR_W-1:0]   wr_addr;
  logic                        wr_en;
  logic                        full;
  logic                        empty;
  deq_pkg::deq_op_t            in_op;

  assign in_op = deq_pkg::deq_op_t'(in_operation);
  assign full  = (cnt_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (cnt_r == '0);

  // read address from the pointers as they stand when the request is taken
  always_comb begin
    case (in_op)
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: rd_addr = deq_pkg::ring_prev(back_r);
      deq_pkg::OP_READ_INDEX: rd_addr = deq_pkg::ring_add(deq_pkg::SUM_W'(front_r),
                                                          deq_pkg::SUM_W'(in_position));
      default: rd_addr = front_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      value_r   <= in_value;
      pos_r     <= in_position;
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    cnt_nxt    = cnt_r;
    data_nxt   = '0;
    status_nxt = deq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    case (op_r)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          back_nxt = deq_pkg::ring_next(back_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        wr_addr = deq_pkg::ring_prev(front_r);
        if (full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          front_nxt = wr_addr;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          data_nxt = rd_data_r;
          back_nxt = deq_pkg::ring_prev(back_r);
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          data_nxt  = rd_data_r;
          front_nxt = deq_pkg::ring_next(front_r);
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      deq_pkg::OP_PEEK_BACK, deq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          data_nxt = rd_data_r;
        end
      end
      deq_pkg::OP_READ_INDEX: begin
        // past the end reads as zero with status ok
        if (deq_pkg::SUM_W'(pos_r) < deq_pkg::SUM_W'(cnt_r)) begin
          data_nxt = rd_data_r;
        end
      end
      default: begin
        front_nxt = '0;
        back_nxt  = '0;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd.commit) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      occ_r    <= cnt_nxt;
    end
  end

  assign out_data      = data_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  `DEQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
  `DEQ_ASSERT_IMP(a_ptr_consistent, 1'b1,
    back_r == deq_pkg::ring_add(deq_pkg::SUM_W'(front_r), deq_pkg::SUM_W'(cnt_r)))
  `DEQ_ASSERT_NXT(a_full_push_holds,
    cmd.commit && full && (op_r == deq_pkg::OP_PUSH_BACK || op_r == deq_pkg::OP_PUSH_FRONT),
    $stable(cnt_r) && $stable(front_r) && $stable(back_r))

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Double-ended queue of 64-bit words on a 16-slot ring: one request in, one result out.
// A request is latched at acceptance, with the word store read at the slot it addresses,
// and committed from the execute state. Its result is valid after the commit, and no new
// request is taken before the commit. The execute state is there because the word store
// has a registered read port. The result sits in an output register, and the next request
// is accepted while it waits; a commit stalls only while a previous result is still
// unclaimed. Requests: push back/front, pop back/front, peek back/front, read at a position
// from the front, clear. No clearing pass after reset; unwritten slots are never read.
// Depends on deq_pkg, deq_ctrl and deq_datapath.

module double_ended_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] operation, [66:3] value, [70:67] position, [71] zero
  input  logic [deq_pkg::IN_TW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [63:0] data, [65:64] status, [70:66] occupancy, [71] zero
  output logic [deq_pkg::OUT_TW-1:0]  out_tdata
);

  deq_pkg::deq_cmd_t                 cmd;
  logic [deq_pkg::DATA_W-1:0]        res_data;
  logic [deq_pkg::STAT_W-1:0]        res_status;
  logic [deq_pkg::CNT_W-1:0]         res_occ;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  deq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_tdata[deq_pkg::OP_W-1:0]),
    .in_value      (in_tdata[deq_pkg::OP_W +: deq_pkg::DATA_W]),
    .in_position   (in_tdata[deq_pkg::OP_W + deq_pkg::DATA_W +: deq_pkg::POS_W]),
    .out_data      (res_data),
    .out_status    (res_status),
    .out_occupancy (res_occ)
  );

  assign out_tdata = deq_pkg::OUT_TW'({res_occ, res_status, res_data});

endmodule

// ----- bench/deq_checker.sv -----
// Result checker for the double-ended queue: watches both stream channels, keeps its own
// copy of the ring, predicts each result and compares it against the block's output.
// Depends on deq_pkg for widths and operation/status codes.
module deq_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  // [2:0] operation, [66:3] value, [70:67] position, [71] zero
  input  logic [deq_pkg::IN_TW-1:0]  in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  // [63:0] data, [65:64] status, [70:66] occupancy, [71] zero
  input  logic [deq_pkg::OUT_TW-1:0] out_tdata,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [deq_pkg::DATA_W-1:0] data;
    deq_pkg::deq_status_t       status;
    logic [deq_pkg::CNT_W-1:0]  occupancy;
  } deq_result_t;

  deq_result_t                results_due[$];
  logic [deq_pkg::DATA_W-1:0] ring_words[deq_pkg::DEPTH];
  logic [deq_pkg::PTR_W-1:0]  head_slot;
  logic [deq_pkg::PTR_W-1:0]  tail_slot;
  logic [deq_pkg::CNT_W-1:0]  word_count;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [deq_pkg::PTR_W-1:0] slot_after(
      input logic [deq_pkg::PTR_W-1:0] p);
    return (p == deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [deq_pkg::PTR_W-1:0] slot_before(
      input logic [deq_pkg::PTR_W-1:0] p);
    return (p == '0) ? deq_pkg::PTR_W'(deq_pkg::DEPTH - 1) : p - 1'b1;
  endfunction

  // applies one request to the ring copy and returns the result it should give
  function automatic deq_result_t deque_outcome(input deq_pkg::deq_op_t op,
                                                input logic [deq_pkg::DATA_W-1:0] val,
                                                input logic [deq_pkg::POS_W-1:0] pos);
    deq_result_t r;
    int          s;
    r.data = '0;
    r.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (word_count >= deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
          r.status = deq_pkg::ST_FULL;
        end else if (op == deq_pkg::OP_PUSH_BACK) begin
          ring_words[tail_slot] = val;
          tail_slot = slot_after(tail_slot);
          word_count++;
        end else begin
          head_slot = slot_before(head_slot);
          ring_words[head_slot] = val;
          word_count++;
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT,
      deq_pkg::OP_PEEK_BACK, deq_pkg::OP_PEEK_FRONT: begin
        if (word_count == '0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          case (op)
            deq_pkg::OP_POP_BACK: begin
              tail_slot = slot_before(tail_slot);
              r.data = ring_words[tail_slot];
              word_count--;
            end
            deq_pkg::OP_POP_FRONT: begin
              r.data = ring_words[head_slot];
              head_slot = slot_after(head_slot);
              word_count--;
            end
            deq_pkg::OP_PEEK_BACK: r.data = ring_words[slot_before(tail_slot)];
            default: r.data = ring_words[head_slot];
          endcase
        end
      end
      deq_pkg::OP_READ_INDEX: begin
        // past the end gives zero data with ok status
        if (pos < word_count) begin
          s = int'(head_slot) + int'(pos);
          if (s >= deq_pkg::DEPTH) s -= deq_pkg::DEPTH;
          r.data = ring_words[deq_pkg::PTR_W'(s)];
        end
      end
      default: begin
        head_slot = '0;
        tail_slot = '0;
        word_count = '0;
      end
    endcase
    r.occupancy = word_count;
    return r;
  endfunction

  always @(posedge clk) begin
    deq_result_t want;
    logic [deq_pkg::DATA_W-1:0] got_data;
    logic [deq_pkg::STAT_W-1:0] got_status;
    logic [deq_pkg::CNT_W-1:0]  got_occ;
    if (!rst_n) begin
      head_slot = '0;
      tail_slot = '0;
      word_count = '0;
      results_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        results_due.insert(results_due.size(),
                           deque_outcome(deq_pkg::deq_op_t'(in_tdata[deq_pkg::OP_W-1:0]),
                                         in_tdata[deq_pkg::OP_W +: deq_pkg::DATA_W],
                                         in_tdata[deq_pkg::OP_W + deq_pkg::DATA_W +:
                                                  deq_pkg::POS_W]));
      end
      if (out_tvalid && out_tready) begin
        got_data = out_tdata[deq_pkg::DATA_W-1:0];
        got_status = out_tdata[deq_pkg::DATA_W +: deq_pkg::STAT_W];
        got_occ = out_tdata[deq_pkg::DATA_W + deq_pkg::STAT_W +: deq_pkg::CNT_W];
        if (results_due.size() == 0) begin
          report($sformatf("result with no request outstanding, data %h", got_data));
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (got_data !== want.data)
            report($sformatf("data %h, expected %h", got_data, want.data));
          if (got_status !== want.status)
            report($sformatf("status %0d, expected %0d", got_status, want.status));
          if (got_occ !== want.occupancy)
            report($sformatf("occupancy %0d, expected %0d", got_occ, want.occupancy));
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ----- bench/double_ended_queue_test.sv -----
// Top of the double-ended queue bench: clock, reset, request stimulus and output back-pressure.
// Instantiates double_ended_queue and deq_checker; uses deq_pkg for codes and widths.
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1820;
  localparam int QUIET_TAIL      = 220;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} stim_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [deq_pkg::IN_TW-1:0]  in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [deq_pkg::OUT_TW-1:0] out_tdata;
  int                         fail_count;
  int                         pending;

  int requests_taken = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  deq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // called at a falling edge, returns at the falling edge after acceptance;
  // ready is looked at on the falling edge, where it is settled for the next rising one
  task automatic send_request(input deq_pkg::deq_op_t op,
                              input logic [deq_pkg::DATA_W-1:0] val,
                              input logic [deq_pkg::POS_W-1:0] pos);
    int gap;
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= deq_pkg::IN_TW'({pos, val, op});
    do begin
      taken = in_tready;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    requests_taken++;
    @(negedge clk);
  endtask

  function automatic logic [deq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic deq_pkg::deq_op_t pick_op(input stim_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 35) return deq_pkg::OP_PUSH_BACK;
        if (r < 65) return deq_pkg::OP_PUSH_FRONT;
        if (r < 72) return deq_pkg::OP_POP_BACK;
        if (r < 79) return deq_pkg::OP_POP_FRONT;
        if (r < 84) return deq_pkg::OP_PEEK_BACK;
        if (r < 89) return deq_pkg::OP_PEEK_FRONT;
      end
      MODE_DRAIN: begin
        if (r < 10) return deq_pkg::OP_PUSH_BACK;
        if (r < 20) return deq_pkg::OP_PUSH_FRONT;
        if (r < 45) return deq_pkg::OP_POP_BACK;
        if (r < 70) return deq_pkg::OP_POP_FRONT;
        if (r < 77) return deq_pkg::OP_PEEK_BACK;
        if (r < 84) return deq_pkg::OP_PEEK_FRONT;
      end
      default: begin
        if (r < 22) return deq_pkg::OP_PUSH_BACK;
        if (r < 44) return deq_pkg::OP_PUSH_FRONT;
        if (r < 56) return deq_pkg::OP_POP_BACK;
        if (r < 68) return deq_pkg::OP_POP_FRONT;
        if (r < 75) return deq_pkg::OP_PEEK_BACK;
        if (r < 82) return deq_pkg::OP_PEEK_FRONT;
      end
    endcase
    return (r < 98) ? deq_pkg::OP_READ_INDEX : deq_pkg::OP_CLEAR;
  endfunction

  // output side: short random stalls, plus one long hold so the queue backs up
  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!held && requests_taken >= HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_mode_t mode;
    int         seg_len;
    int         sent;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue: every read-type request reports empty or gives zero; pushes then fill it up
    send_request(deq_pkg::OP_POP_BACK, '1, '0);
    send_request(deq_pkg::OP_POP_FRONT, '1, '1);
    send_request(deq_pkg::OP_PEEK_BACK, '0, '0);
    send_request(deq_pkg::OP_PEEK_FRONT, '0, '1);
    send_request(deq_pkg::OP_READ_INDEX, '1, '0);
    send_request(deq_pkg::OP_PUSH_BACK, '1, '1);
    send_request(deq_pkg::OP_PUSH_FRONT, '0, '0);
    send_request(deq_pkg::OP_PEEK_BACK, '0, '0);
    send_request(deq_pkg::OP_PEEK_FRONT, '0, '0);
    send_request(deq_pkg::OP_READ_INDEX, '0, '1);
    for (int i = 0; i < deq_pkg::DEPTH - 2; i++) begin
      send_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                   {$urandom, $urandom}, deq_pkg::POS_W'($urandom_range(0, 15)));
    end
    // full: pushes refused, last slot readable
    send_request(deq_pkg::OP_PUSH_BACK, '1, '0);
    send_request(deq_pkg::OP_PUSH_FRONT, '1, '0);
    send_request(deq_pkg::OP_READ_INDEX, '0, '1);
    send_request(deq_pkg::OP_POP_BACK, '0, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0, '0);
    send_request(deq_pkg::OP_CLEAR, '1, '1);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode = stim_mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(10, 50);
      idle_on = (sent < RANDOM_REQUESTS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && sent < RANDOM_REQUESTS; k++) begin
        send_request(pick_op(mode), pick_word(), deq_pkg::POS_W'($urandom_range(0, 15)));
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
